### rtl/scfd_pkg.sv
// shared types, codes and constants for the serial command frame decoder
package scfd_pkg;

    localparam int MAX_FRAME = 64;
    localparam int HEAD_DEPTH = 5;
    localparam int COUNT_W = 7;

    typedef logic [7:0] byte_t;
    typedef logic [COUNT_W-1:0] count_t;
    typedef logic [2:0] status_t;
    typedef logic [2:0] action_t;
    typedef logic [1:0] axis_t;
    typedef logic [1:0] gain_t;
    typedef logic signed [15:0] value_t;

    localparam count_t FRAME_LIMIT = COUNT_W'(MAX_FRAME);
    localparam count_t SHORT_LIMIT = 7'd2;
    localparam count_t AXIS_ARGS = 7'd3;
    localparam count_t GAIN_ARGS = 7'd4;

    localparam byte_t TERM_CHAR = 8'd35;
    localparam byte_t CMD_AXIS = 8'd99;
    localparam byte_t CMD_GAIN = 8'd115;
    localparam byte_t CMD_ZERO = 8'd122;
    localparam byte_t CMD_RUN = 8'd83;
    localparam byte_t GAIN_P = 8'd80;
    localparam byte_t GAIN_I = 8'd73;
    localparam byte_t GAIN_D = 8'd68;
    localparam byte_t GAIN_W = 8'd87;
    localparam byte_t AXIS_MAX = 8'd3;
    localparam byte_t LOOP_MAX = 8'd1;
    localparam byte_t RUN_STOP = 8'd1;
    localparam byte_t RUN_START = 8'd0;

    localparam gain_t SEL_P = 2'd0;
    localparam gain_t SEL_I = 2'd1;
    localparam gain_t SEL_D = 2'd2;
    localparam gain_t SEL_W = 2'd3;

    localparam status_t ST_OK = 3'd0;
    localparam status_t ST_SHORT = 3'd1;
    localparam status_t ST_CHECKSUM = 3'd2;
    localparam status_t ST_LENGTH = 3'd3;
    localparam status_t ST_AXIS = 3'd4;
    localparam status_t ST_IGNORED = 3'd5;
    localparam status_t ST_OVERFLOW = 3'd6;

    localparam action_t ACT_NONE = 3'd0;
    localparam action_t ACT_AXIS = 3'd1;
    localparam action_t ACT_GAIN = 3'd2;
    localparam action_t ACT_ZERO = 3'd3;
    localparam action_t ACT_STOP = 3'd4;
    localparam action_t ACT_START = 3'd5;

endpackage

### rtl/scfd_byte_if.sv
// received byte channel
interface scfd_byte_if;
    logic valid;
    logic ready;
    scfd_pkg::byte_t rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

### rtl/scfd_result_if.sv
// decoded frame result channel
interface scfd_result_if;
    logic valid;
    logic ready;
    scfd_pkg::status_t status;
    scfd_pkg::action_t action;
    scfd_pkg::axis_t axis;
    scfd_pkg::gain_t gain_select;
    scfd_pkg::value_t value;

    modport source (output valid, output status, output action, output axis,
                    output gain_select, output value, input ready);
    modport sink (input valid, input status, input action, input axis,
                  input gain_select, input value, output ready);
endinterface

### rtl/serial_command_frame_decoder.sv
// serial command frame decoder: gathers bytes into '#'-terminated frames and decodes them
// a terminator word passes the input byte register and then loads the result register
// throughput: one byte word per cycle; the byte register stalls only when a terminator
//   meets a result word that is still waiting to be taken
// reset: rst_n clears the frame count, sum, overflow flag and both valid flags;
//   head byte storage and result payload are not reset
module serial_command_frame_decoder (
    input logic clk,
    input logic rst_n,
    scfd_byte_if.sink rx,
    scfd_result_if.source res
);

    // input byte register
    logic in_valid_reg;
    scfd_pkg::byte_t in_byte_reg;

    // frame state
    scfd_pkg::count_t byte_count_reg;
    scfd_pkg::byte_t running_sum_reg;
    scfd_pkg::byte_t last_byte_reg;
    logic overflowed_reg;
    scfd_pkg::byte_t head_reg [scfd_pkg::HEAD_DEPTH];

    // result register
    logic out_valid_reg;
    scfd_pkg::status_t status_reg;
    scfd_pkg::action_t action_reg;
    scfd_pkg::axis_t axis_reg;
    scfd_pkg::gain_t gain_reg;
    scfd_pkg::value_t value_reg;

    logic is_term;
    logic advance;
    logic store_byte;

    // decoded values for the frame held in the state registers
    scfd_pkg::status_t status_next;
    scfd_pkg::action_t action_next;
    scfd_pkg::axis_t axis_next;
    scfd_pkg::gain_t gain_next;
    scfd_pkg::value_t value_next;
    scfd_pkg::byte_t sum_wo_check;
    scfd_pkg::count_t nargs;
    logic [15:0] gain_value;

    // a terminator needs the result register free (or emptying this cycle)
    assign is_term = (in_byte_reg == scfd_pkg::TERM_CHAR);
    assign advance = in_valid_reg && (!is_term || !out_valid_reg || res.ready);
    assign rx.ready = !in_valid_reg || advance;
    assign store_byte = advance && !is_term && (byte_count_reg < scfd_pkg::FRAME_LIMIT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (rx.ready)
        begin
            in_valid_reg <= rx.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx.ready && rx.valid)
        begin
            in_byte_reg <= rx.rx_byte;
        end
    end

    // frame counters: cleared by the terminator, frozen once the buffer is full
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg <= '0;
            running_sum_reg <= '0;
            last_byte_reg <= '0;
            overflowed_reg <= 1'b0;
        end
        else if (advance)
        begin
            if (is_term)
            begin
                byte_count_reg <= '0;
                running_sum_reg <= '0;
                last_byte_reg <= '0;
                overflowed_reg <= 1'b0;
            end
            else if (byte_count_reg >= scfd_pkg::FRAME_LIMIT)
            begin
                overflowed_reg <= 1'b1;
            end
            else
            begin
                byte_count_reg <= byte_count_reg + 7'd1;
                running_sum_reg <= running_sum_reg + in_byte_reg;
                last_byte_reg <= in_byte_reg;
            end
        end
    end

    // command and first four argument bytes
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < scfd_pkg::HEAD_DEPTH; i++)
        begin
            if (store_byte && (byte_count_reg == scfd_pkg::COUNT_W'(i)))
            begin
                head_reg[i] <= in_byte_reg;
            end
        end
    end

    // frame decode; checksum is the last stored byte against the sum of the rest
    assign sum_wo_check = running_sum_reg - last_byte_reg;
    assign nargs = byte_count_reg - scfd_pkg::SHORT_LIMIT;
    assign gain_value = {head_reg[3], head_reg[4]};

    always_comb
    begin
        status_next = scfd_pkg::ST_OK;
        action_next = scfd_pkg::ACT_NONE;
        axis_next = '0;
        gain_next = '0;
        value_next = '0;
        if (overflowed_reg)
        begin
            status_next = scfd_pkg::ST_OVERFLOW;
        end
        else if (byte_count_reg <= scfd_pkg::SHORT_LIMIT)
        begin
            status_next = scfd_pkg::ST_SHORT;
        end
        else if (sum_wo_check != last_byte_reg)
        begin
            status_next = scfd_pkg::ST_CHECKSUM;
        end
        else
        begin
            case (head_reg[0])
                scfd_pkg::CMD_AXIS:
                begin
                    if (nargs != scfd_pkg::AXIS_ARGS)
                    begin
                        status_next = scfd_pkg::ST_LENGTH;
                    end
                    else if (head_reg[1] > scfd_pkg::AXIS_MAX)
                    begin
                        status_next = scfd_pkg::ST_AXIS;
                    end
                    else
                    begin
                        action_next = scfd_pkg::ACT_AXIS;
                        axis_next = head_reg[1][1:0];
                        value_next = {head_reg[2], head_reg[3]};
                    end
                end
                scfd_pkg::CMD_GAIN:
                begin
                    if (nargs < scfd_pkg::GAIN_ARGS)
                    begin
                        status_next = scfd_pkg::ST_LENGTH;
                    end
                    else if (head_reg[1] > scfd_pkg::LOOP_MAX)
                    begin
                        status_next = scfd_pkg::ST_AXIS;
                    end
                    else if (gain_value[15])
                    begin
                        status_next = scfd_pkg::ST_IGNORED;
                    end
                    else
                    begin
                        action_next = scfd_pkg::ACT_GAIN;
                        axis_next = head_reg[1][1:0];
                        value_next = gain_value;
                        case (head_reg[2])
                            scfd_pkg::GAIN_P: gain_next = scfd_pkg::SEL_P;
                            scfd_pkg::GAIN_I: gain_next = scfd_pkg::SEL_I;
                            scfd_pkg::GAIN_D: gain_next = scfd_pkg::SEL_D;
                            scfd_pkg::GAIN_W: gain_next = scfd_pkg::SEL_W;
                            default:
                            begin
                                status_next = scfd_pkg::ST_IGNORED;
                                action_next = scfd_pkg::ACT_NONE;
                                axis_next = '0;
                                value_next = '0;
                            end
                        endcase
                    end
                end
                scfd_pkg::CMD_ZERO:
                begin
                    action_next = scfd_pkg::ACT_ZERO;
                end
                scfd_pkg::CMD_RUN:
                begin
                    if (head_reg[1] == scfd_pkg::RUN_STOP)
                    begin
                        action_next = scfd_pkg::ACT_STOP;
                    end
                    else if (head_reg[1] == scfd_pkg::RUN_START)
                    begin
                        action_next = scfd_pkg::ACT_START;
                    end
                    else
                    begin
                        status_next = scfd_pkg::ST_IGNORED;
                    end
                end
                default:
                begin
                    status_next = scfd_pkg::ST_IGNORED;
                end
            endcase
        end
    end

    // result register: loaded by a terminator, emptied when taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && is_term)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && is_term)
        begin
            status_reg <= status_next;
            action_reg <= action_next;
            axis_reg <= axis_next;
            gain_reg <= gain_next;
            value_reg <= value_next;
        end
    end

    assign res.valid = out_valid_reg;
    assign res.status = status_reg;
    assign res.action = action_reg;
    assign res.axis = axis_reg;
    assign res.gain_select = gain_reg;
    assign res.value = value_reg;

`ifndef SYNTHESIS
    // the stored byte count never passes the buffer limit
    a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
        byte_count_reg <= scfd_pkg::FRAME_LIMIT)
        else $error("frame byte count above buffer limit");

    // bytes are only dropped once the buffer is full
    a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
        overflowed_reg |-> (byte_count_reg == scfd_pkg::FRAME_LIMIT))
        else $error("overflow flag set with buffer not full");

    // a refused frame carries no action
    a_refused_no_action: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (status_reg != scfd_pkg::ST_OK)) |->
            (action_reg == scfd_pkg::ACT_NONE))
        else $error("refused frame carries an action");

    // a processed terminator always leaves a result word and an empty frame
    a_term_result: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && is_term) |=> (out_valid_reg && (byte_count_reg == '0) && !overflowed_reg))
        else $error("terminator did not produce a result or clear the frame");
`endif

endmodule

### bench/scfd_tb_pkg.sv
`timescale 1ns / 1ps
// frame tracker class: predicts decoded results and checks the result words
package scfd_tb_pkg;

    typedef struct packed {
        scfd_pkg::status_t status;
        scfd_pkg::action_t action;
        scfd_pkg::axis_t axis;
        scfd_pkg::gain_t gain_select;
        scfd_pkg::value_t value;
    } frame_result_t;

    class frame_tracker;
        scfd_pkg::count_t stored;
        scfd_pkg::byte_t sum_acc;
        scfd_pkg::byte_t newest;
        scfd_pkg::byte_t head[scfd_pkg::HEAD_DEPTH];
        bit dropped;
        frame_result_t awaited[$];
        int mismatches;

        function new();
            foreach (head[i]) head[i] = '0;
            clear_frame();
            mismatches = 0;
        endfunction

        function void clear_frame();
            stored = '0;
            sum_acc = '0;
            newest = '0;
            dropped = 1'b0;
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        function frame_result_t decode_frame();
            frame_result_t r;
            scfd_pkg::count_t nargs;
            logic [15:0] gv;
            r = '0;
            nargs = stored - scfd_pkg::SHORT_LIMIT;
            gv = {head[3], head[4]};
            if (dropped)
                r.status = scfd_pkg::ST_OVERFLOW;
            else if (stored <= scfd_pkg::SHORT_LIMIT)
                r.status = scfd_pkg::ST_SHORT;
            else if (scfd_pkg::byte_t'(sum_acc - newest) != newest)
                r.status = scfd_pkg::ST_CHECKSUM;
            else if (head[0] == scfd_pkg::CMD_AXIS)
            begin
                if (nargs != scfd_pkg::AXIS_ARGS)
                    r.status = scfd_pkg::ST_LENGTH;
                else if (head[1] > scfd_pkg::AXIS_MAX)
                    r.status = scfd_pkg::ST_AXIS;
                else
                begin
                    r.action = scfd_pkg::ACT_AXIS;
                    r.axis = head[1][1:0];
                    r.value = {head[2], head[3]};
                end
            end
            else if (head[0] == scfd_pkg::CMD_GAIN)
            begin
                if (nargs < scfd_pkg::GAIN_ARGS)
                    r.status = scfd_pkg::ST_LENGTH;
                else if (head[1] > scfd_pkg::LOOP_MAX)
                    r.status = scfd_pkg::ST_AXIS;
                else if (gv[15])
                    r.status = scfd_pkg::ST_IGNORED;
                else
                begin
                    r.action = scfd_pkg::ACT_GAIN;
                    r.axis = head[1][1:0];
                    r.value = gv;
                    case (head[2])
                        scfd_pkg::GAIN_P: r.gain_select = scfd_pkg::SEL_P;
                        scfd_pkg::GAIN_I: r.gain_select = scfd_pkg::SEL_I;
                        scfd_pkg::GAIN_D: r.gain_select = scfd_pkg::SEL_D;
                        scfd_pkg::GAIN_W: r.gain_select = scfd_pkg::SEL_W;
                        default:
                        begin
                            r = '0;
                            r.status = scfd_pkg::ST_IGNORED;
                        end
                    endcase
                end
            end
            else if (head[0] == scfd_pkg::CMD_ZERO)
                r.action = scfd_pkg::ACT_ZERO;
            else if (head[0] == scfd_pkg::CMD_RUN)
            begin
                if (head[1] == scfd_pkg::RUN_STOP)
                    r.action = scfd_pkg::ACT_STOP;
                else if (head[1] == scfd_pkg::RUN_START)
                    r.action = scfd_pkg::ACT_START;
                else
                    r.status = scfd_pkg::ST_IGNORED;
            end
            else
                r.status = scfd_pkg::ST_IGNORED;
            return r;
        endfunction

        // called for every byte word accepted by the block
        function void note_byte(scfd_pkg::byte_t b);
            if (b == scfd_pkg::TERM_CHAR)
            begin
                awaited.push_back(decode_frame());
                clear_frame();
            end
            else if (stored >= scfd_pkg::FRAME_LIMIT)
                dropped = 1'b1;
            else
            begin
                if (stored < scfd_pkg::count_t'(scfd_pkg::HEAD_DEPTH))
                    head[stored] = b;
                sum_acc += b;
                newest = b;
                stored++;
            end
        endfunction

        // called for every result word accepted from the block
        function void check_result(frame_result_t got);
            frame_result_t want;
            if (awaited.size() == 0)
            begin
                $error("result word with no frame pending: status %0d action %0d",
                       got.status, got.action);
                mismatches++;
                return;
            end
            want = awaited.pop_front();
            if (got.status !== want.status)
            begin
                $error("status: expected %0d, actual %0d", want.status, got.status);
                mismatches++;
            end
            if (got.action !== want.action)
            begin
                $error("action: expected %0d, actual %0d", want.action, got.action);
                mismatches++;
            end
            if (got.axis !== want.axis)
            begin
                $error("axis: expected %0d, actual %0d", want.axis, got.axis);
                mismatches++;
            end
            if (got.gain_select !== want.gain_select)
            begin
                $error("gain_select: expected %0d, actual %0d", want.gain_select,
                       got.gain_select);
                mismatches++;
            end
            if (got.value !== want.value)
            begin
                $error("value: expected %0d, actual %0d", want.value, got.value);
                mismatches++;
            end
        endfunction
    endclass

endpackage

### bench/tb_serial_command_frame_decoder.sv
`timescale 1ns / 1ps
// top-level bench for the serial command frame decoder
module tb_serial_command_frame_decoder;

    // cycles with no word moving on either side before the run is declared hung
    localparam int STALL_LIMIT = 1000;
    // random byte words sent after the directed frames
    localparam int RANDOM_BYTES = 880;
    localparam int PHASES = 4;

    localparam scfd_pkg::byte_t GAIN_LETTERS[4] = '{scfd_pkg::GAIN_P, scfd_pkg::GAIN_I,
                                                    scfd_pkg::GAIN_D, scfd_pkg::GAIN_W};

    logic clk;
    logic rst_n;

    scfd_byte_if rx_ch();
    scfd_result_if res_ch();

    serial_command_frame_decoder u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .rx(rx_ch),
        .res(res_ch)
    );

    scfd_tb_pkg::frame_tracker tracker = new();

    // when set, neither side inserts idle cycles
    bit calm;
    int bytes_sent;
    int idle_cycles = 0;
    // frame under construction: command and argument bytes, no checksum
    scfd_pkg::byte_t frame_body[$];

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // hang detection: any accepted word on either channel restarts the count
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((rx_ch.valid && rx_ch.ready) || (res_ch.valid && res_ch.ready))
                idle_cycles <= 0;
            else if (idle_cycles >= STALL_LIMIT)
            begin
                $display("tb: failure");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // random byte that never closes a frame by accident
    function automatic scfd_pkg::byte_t body_byte(int hi_lim);
        scfd_pkg::byte_t b;
        do
            b = scfd_pkg::byte_t'($urandom_range(0, hi_lim));
        while (b == scfd_pkg::TERM_CHAR);
        return b;
    endfunction

    function automatic scfd_pkg::byte_t body_sum();
        scfd_pkg::byte_t s;
        s = '0;
        foreach (frame_body[i]) s += frame_body[i];
        return s;
    endfunction

    // one byte word: optional idle gap, then hold valid until the block takes it
    task automatic send_byte(input scfd_pkg::byte_t b);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 3);
        repeat (gap)
        begin
            @(negedge clk);
            rx_ch.valid <= 1'b0;
        end
        @(negedge clk);
        rx_ch.valid <= 1'b1;
        rx_ch.rx_byte <= b;
        do
            @(posedge clk);
        while (rx_ch.ready !== 1'b1);
        tracker.note_byte(b);
        bytes_sent++;
    endtask

    // body, then checksum (optionally with one bit flipped), then terminator
    task automatic send_frame(input bit bad_sum);
        scfd_pkg::byte_t chk;
        chk = body_sum();
        if (bad_sum)
            chk ^= scfd_pkg::byte_t'(8'd1 << $urandom_range(0, 7));
        foreach (frame_body[i]) send_byte(frame_body[i]);
        send_byte(chk);
        send_byte(scfd_pkg::TERM_CHAR);
    endtask

    // sender goes quiet until every predicted result word has been taken
    task automatic drain_results();
        @(negedge clk);
        rx_ch.valid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
    endtask

    // mostly sensible frames for one of the known commands, some off-nominal
    task automatic build_frame();
        int nargs;
        scfd_pkg::byte_t arg;
        frame_body.delete();
        case ($urandom_range(0, 4))
            0:
            begin
                // joystick axis: exact length most of the time
                frame_body.push_back(scfd_pkg::CMD_AXIS);
                nargs = ($urandom_range(0, 9) < 8) ? 3 : $urandom_range(0, 5);
                for (int i = 1; i <= nargs; i++)
                begin
                    if (i == 1 && $urandom_range(0, 4) != 0)
                        arg = scfd_pkg::byte_t'($urandom_range(0, 3));
                    else
                        arg = body_byte(255);
                    frame_body.push_back(arg);
                end
            end
            1:
            begin
                // gain write: loop, letter, value high, value low, maybe extras
                frame_body.push_back(scfd_pkg::CMD_GAIN);
                nargs = ($urandom_range(0, 9) < 8) ? $urandom_range(4, 6) : $urandom_range(0, 3);
                for (int i = 1; i <= nargs; i++)
                begin
                    if (i == 1 && $urandom_range(0, 6) != 0)
                        arg = scfd_pkg::byte_t'($urandom_range(0, 1));
                    else if (i == 2 && $urandom_range(0, 6) != 0)
                        arg = GAIN_LETTERS[$urandom_range(0, 3)];
                    else if (i == 3 && $urandom_range(0, 2) != 0)
                        arg = body_byte(127);
                    else
                        arg = body_byte(255);
                    frame_body.push_back(arg);
                end
            end
            2:
            begin
                frame_body.push_back(scfd_pkg::CMD_ZERO);
                nargs = $urandom_range(1, 3);
                repeat (nargs) frame_body.push_back(body_byte(255));
            end
            3:
            begin
                // run control: start or stop argument, sometimes junk or extras
                frame_body.push_back(scfd_pkg::CMD_RUN);
                nargs = ($urandom_range(0, 4) != 0) ? 1 : $urandom_range(1, 3);
                for (int i = 1; i <= nargs; i++)
                begin
                    if (i == 1 && $urandom_range(0, 4) != 0)
                        arg = scfd_pkg::byte_t'($urandom_range(0, 1));
                    else
                        arg = body_byte(255);
                    frame_body.push_back(arg);
                end
            end
            default:
            begin
                frame_body.push_back(body_byte(255));
                nargs = $urandom_range(0, 5);
                repeat (nargs) frame_body.push_back(body_byte(255));
            end
        endcase
    endtask

    task automatic random_frame();
        int pick;
        bit bad;
        pick = $urandom_range(0, 99);
        if (pick < 6)
        begin
            // line noise, stray terminators included
            repeat ($urandom_range(1, 6))
                send_byte(($urandom_range(0, 3) == 0) ? scfd_pkg::TERM_CHAR
                                                      : scfd_pkg::byte_t'($urandom));
        end
        else if (pick < 8)
        begin
            // long frame straddling the buffer limit
            frame_body.delete();
            frame_body.push_back($urandom_range(0, 1) ? scfd_pkg::CMD_ZERO : body_byte(255));
            repeat ($urandom_range(59, 67)) frame_body.push_back(body_byte(255));
            send_frame(1'b0);
        end
        else
        begin
            bad = (pick < 18);
            // a good checksum equal to the terminator would cut the frame short
            do
                build_frame();
            while (!bad && body_sum() == scfd_pkg::TERM_CHAR);
            send_frame(bad);
        end
    endtask

    // result side: random stall, then ready until a result word is taken
    initial
    begin : result_sink
        int gap;
        scfd_tb_pkg::frame_result_t got;
        res_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            gap = calm ? 0 : $urandom_range(0, 3);
            repeat (gap)
            begin
                @(negedge clk);
                res_ch.ready <= 1'b0;
            end
            @(negedge clk);
            res_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (res_ch.valid !== 1'b1);
            got.status = res_ch.status;
            got.action = res_ch.action;
            got.axis = res_ch.axis;
            got.gain_select = res_ch.gain_select;
            got.value = res_ch.value;
            tracker.check_result(got);
        end
    end

    initial
    begin : stimulus
        int target;
        rst_n = 1'b0;
        rx_ch.valid = 1'b0;
        rx_ch.rx_byte = '0;
        calm = 1'b0;
        bytes_sent = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: empty frame and too-short frames
        send_byte(scfd_pkg::TERM_CHAR);
        frame_body = '{scfd_pkg::CMD_ZERO};
        send_frame(1'b0);
        // axis command: extremes, wrong lengths, bad axis
        frame_body = '{scfd_pkg::CMD_AXIS, 8'd3, 8'h80, 8'h00};
        send_frame(1'b0);
        frame_body = '{scfd_pkg::CMD_AXIS, 8'd0, 8'h7F, 8'hFF};
        send_frame(1'b0);
        frame_body = '{scfd_pkg::CMD_AXIS, 8'd1, 8'h12};
        send_frame(1'b0);
        frame_body = '{scfd_pkg::CMD_AXIS, 8'd2, 8'h00, 8'h00, 8'h00};
        send_frame(1'b0);
        frame_body = '{scfd_pkg::CMD_AXIS, 8'd4, 8'h01, 8'h02};
        send_frame(1'b0);
        frame_body = '{scfd_pkg::CMD_AXIS, 8'hFF, 8'h00, 8'h00};
        send_frame(1'b0);
        // gain command: short, bad loop, negative, unknown letter, every letter, extras
        frame_body = '{scfd_pkg::CMD_GAIN, 8'd0, scfd_pkg::GAIN_P, 8'h01};
        send_frame(1'b0);
        frame_body = '{scfd_pkg::CMD_GAIN, 8'd2, scfd_pkg::GAIN_P, 8'h00, 8'h01};
        send_frame(1'b0);
        frame_body = '{scfd_pkg::CMD_GAIN, 8'd0, scfd_pkg::GAIN_P, 8'h80, 8'h00};
        send_frame(1'b0);
        frame_body = '{scfd_pkg::CMD_GAIN, 8'd1, 8'h58, 8'h00, 8'h05};
        send_frame(1'b0);
        frame_body = '{scfd_pkg::CMD_GAIN, 8'd0, scfd_pkg::GAIN_P, 8'h7F, 8'hFF};
        send_frame(1'b0);
        frame_body = '{scfd_pkg::CMD_GAIN, 8'd1, scfd_pkg::GAIN_I, 8'h00, 8'h00};
        send_frame(1'b0);
        frame_body = '{scfd_pkg::CMD_GAIN, 8'd0, scfd_pkg::GAIN_D, 8'h12, 8'h34};
        send_frame(1'b0);
        frame_body = '{scfd_pkg::CMD_GAIN, 8'd1, scfd_pkg::GAIN_W, 8'h01, 8'h00,
                       8'hAA, 8'h55};
        send_frame(1'b0);
        // zero integral, run control, unknown commands, bad checksum
        frame_body = '{scfd_pkg::CMD_ZERO, 8'hFF};
        send_frame(1'b0);
        frame_body = '{scfd_pkg::CMD_RUN, scfd_pkg::RUN_STOP};
        send_frame(1'b0);
        frame_body = '{scfd_pkg::CMD_RUN, scfd_pkg::RUN_START};
        send_frame(1'b0);
        frame_body = '{scfd_pkg::CMD_RUN, 8'd2};
        send_frame(1'b0);
        frame_body = '{8'hFF, 8'h00};
        send_frame(1'b0);
        frame_body = '{8'h00, 8'h01};
        send_frame(1'b0);
        frame_body = '{scfd_pkg::CMD_AXIS, 8'd1, 8'h00, 8'h05};
        send_frame(1'b1);
        // exactly a full buffer, then one byte over, then well past it
        frame_body = '{scfd_pkg::CMD_ZERO};
        repeat (62) frame_body.push_back(8'h01);
        send_frame(1'b0);
        frame_body = '{scfd_pkg::CMD_ZERO};
        repeat (63) frame_body.push_back(8'h01);
        send_frame(1'b0);
        frame_body = '{scfd_pkg::CMD_ZERO};
        repeat (70) frame_body.push_back(8'h02);
        send_frame(1'b0);

        // random phases; one runs without idle gaps, each ends with a full drain
        target = bytes_sent;
        for (int phase = 0; phase < PHASES; phase++)
        begin
            calm = (phase == 2);
            target += RANDOM_BYTES / PHASES;
            while (bytes_sent < target)
                random_frame();
            drain_results();
        end

        calm = 1'b0;
        // idle before the final check of mismatches and pending result words
        repeat (4) @(posedge clk);
        if (tracker.mismatches == 0 && tracker.pending() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

### serial_command_frame_decoder.f
rtl/scfd_pkg.sv
rtl/scfd_byte_if.sv
rtl/scfd_result_if.sv
rtl/serial_command_frame_decoder.sv
bench/scfd_tb_pkg.sv
bench/tb_serial_command_frame_decoder.sv
